// ===== hw/rtl/bmpd_pkg.sv =====
`default_nettype none

package bmpd_pkg;

   // Largest width or height accepted
   localparam int MAX_DIM = 2048;
   localparam int DIM_W   = $clog2(MAX_DIM + 1);

   localparam logic [31:0] MAX_DIM_WORD = 32'(MAX_DIM);

   // Header byte positions where a field completes
   localparam logic [31:0] POS_SIGNATURE   = 32'd1;
   localparam logic [31:0] POS_OFFSET      = 32'd13;
   localparam logic [31:0] POS_WIDTH       = 32'd21;
   localparam logic [31:0] POS_HEIGHT      = 32'd25;
   localparam logic [31:0] POS_PLANES      = 32'd27;
   localparam logic [31:0] POS_DEPTH       = 32'd29;
   localparam logic [31:0] POS_COMPRESSION = 32'd33;
   localparam logic [31:0] HEADER_BYTES    = 32'd34;

   localparam logic [15:0] SIGNATURE  = 16'h4D42;
   localparam logic [15:0] PLANES     = 16'd1;
   localparam logic [15:0] PIXEL_BITS = 16'd24;

   typedef enum logic [1:0] {
      KIND_WIDTH  = 2'd0,
      KIND_HEIGHT = 2'd1,
      KIND_PIXEL  = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_HEIGHT = 3'd1,
      PH_SKIP   = 3'd2,
      PH_PIXELS = 3'd3,
      PH_PAD    = 3'd4,
      PH_DONE   = 3'd5,
      PH_ERROR  = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] value;
      logic [10:0] row;
      logic [10:0] column;
      logic        last_of_image;
   } rsp_item_type;

   // Registered input item handed to the parser
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bmpd_ifs.sv =====
`default_nettype none

interface bmpd_req_if;
   logic                  valid;
   logic                  ready;
   bmpd_pkg::req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface bmpd_rsp_if;
   logic                  valid;
   logic                  ready;
   bmpd_pkg::rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bmpd_in_stage.sv =====
`default_nettype none

module bmpd_in_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   bmpd_req_if.sink                 req_bus,
   output bmpd_pkg::stage_type      stage,
   input  wire logic                consume
);

   logic                   main_valid_ff;
   bmpd_pkg::req_item_type main_item_ff;
   logic                   skid_valid_ff;
   bmpd_pkg::req_item_type skid_item_ff;
   logic                   accept;
   logic                   main_free;

   // ready comes straight from a flop; the skid entry catches the item
   // taken while the parser stalls
   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && !skid_valid_ff;
   assign main_free     = !main_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         main_item_ff <= skid_valid_ff ? skid_item_ff : req_bus.item;
      end
      if (!main_free && accept) begin
         skid_item_ff <= req_bus.item;
      end
   end

   assign stage.valid = main_valid_ff;
   assign stage.item  = main_item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bmpd_parser.sv =====
`default_nettype none

module bmpd_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bmpd_pkg::stage_type stage,
   output logic                     consume,
   bmpd_rsp_if.source               rsp_bus
);

   localparam int DW = bmpd_pkg::DIM_W;

   bmpd_pkg::phase_type phase_ff, phase_in;
   logic [31:0]         pos_ff, pos_in;
   logic [31:0]         hw_ff, hw_in;
   logic [31:0]         offset_ff, offset_in;
   logic [DW-1:0]       width_ff, width_in;
   logic [DW-1:0]       height_ff, height_in;
   logic                top_down_ff, top_down_in;
   logic [10:0]         part_ff, part_in;
   logic [1:0]          bip_ff, bip_in;
   logic [DW-1:0]       col_ff, col_in;
   logic [DW-1:0]       frow_ff, frow_in;
   logic [1:0]          pad_ff, pad_in;

   logic                   out_valid_ff;
   bmpd_pkg::rsp_item_type out_item_ff;
   logic                   out_free;

   logic [7:0]          b;
   logic                sof;
   bmpd_pkg::phase_type eff_phase;
   bmpd_pkg::phase_type data_phase;
   logic [31:0]         eff_pos;
   logic [31:0]         hw_next;
   logic [31:0]         height_mag;
   logic                hdr_fail;
   logic                empty_image;
   logic                pixel_now;
   logic [DW-1:0]       col_inc;
   logic [DW-1:0]       frow_inc;
   logic [15:0]         pix_word;
   logic [31:0]         drow_wide;
   logic [31:0]         col_wide;
   logic                last_pix;

   logic                   res_valid;
   bmpd_pkg::rsp_item_type res_item;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign consume  = stage.valid && out_free;

   assign b   = stage.item.data_byte;
   assign sof = stage.item.start_of_file;

   // start of file acts as a reset taken in the same cycle as its byte
   assign eff_phase = sof ? bmpd_pkg::PH_HEADER : phase_ff;
   assign eff_pos   = sof ? '0 : pos_ff;
   assign hw_next   = {b, (sof ? 24'd0 : hw_ff[31:8])};

   assign height_mag = hw_next[31] ? (~hw_next + 32'd1) : hw_next;

   always_comb begin
      hdr_fail = 1'b0;
      if (eff_pos == bmpd_pkg::POS_SIGNATURE && hw_next[31:16] != bmpd_pkg::SIGNATURE) begin
         hdr_fail = 1'b1;
      end
      if (eff_pos == bmpd_pkg::POS_OFFSET && hw_next < bmpd_pkg::HEADER_BYTES) begin
         hdr_fail = 1'b1;
      end
      if (eff_pos == bmpd_pkg::POS_WIDTH && hw_next > bmpd_pkg::MAX_DIM_WORD) begin
         hdr_fail = 1'b1;
      end
      if (eff_pos == bmpd_pkg::POS_HEIGHT && height_mag > bmpd_pkg::MAX_DIM_WORD) begin
         hdr_fail = 1'b1;
      end
      if (eff_pos == bmpd_pkg::POS_PLANES && hw_next[31:16] != bmpd_pkg::PLANES) begin
         hdr_fail = 1'b1;
      end
      if (eff_pos == bmpd_pkg::POS_DEPTH && hw_next[31:16] != bmpd_pkg::PIXEL_BITS) begin
         hdr_fail = 1'b1;
      end
      if (eff_pos == bmpd_pkg::POS_COMPRESSION && hw_next != 32'd0) begin
         hdr_fail = 1'b1;
      end
   end

   assign empty_image = (width_ff == '0) || (height_ff == '0);

   // the height byte is also the first byte of the skip/data area
   assign data_phase = (eff_phase == bmpd_pkg::PH_HEIGHT) ? bmpd_pkg::PH_SKIP : eff_phase;
   assign pixel_now  = (data_phase == bmpd_pkg::PH_PIXELS) ||
                       (data_phase == bmpd_pkg::PH_SKIP && pos_ff == offset_ff);

   assign col_inc  = col_ff + DW'(1);
   assign frow_inc = frow_ff + DW'(1);
   assign pix_word = {b[7:3], part_ff};
   assign drow_wide = top_down_ff ? 32'(frow_ff)
                                  : (32'(height_ff) - 32'd1 - 32'(frow_ff));
   assign col_wide  = 32'(col_ff);
   assign last_pix  = (col_inc == width_ff) && (frow_inc == height_ff);

   // next state
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      hw_in       = hw_ff;
      offset_in   = offset_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      top_down_in = top_down_ff;
      part_in     = part_ff;
      bip_in      = bip_ff;
      col_in      = col_ff;
      frow_in     = frow_ff;
      pad_in      = pad_ff;
      if (sof) begin
         phase_in    = bmpd_pkg::PH_HEADER;
         pos_in      = '0;
         hw_in       = '0;
         offset_in   = '0;
         width_in    = '0;
         height_in   = '0;
         top_down_in = 1'b0;
         part_in     = '0;
         bip_in      = '0;
         col_in      = '0;
         frow_in     = '0;
         pad_in      = '0;
      end
      if (eff_phase == bmpd_pkg::PH_HEADER) begin
         hw_in  = hw_next;
         pos_in = eff_pos + 32'd1;
         if (hdr_fail) begin
            phase_in = bmpd_pkg::PH_ERROR;
         end else begin
            if (eff_pos == bmpd_pkg::POS_OFFSET) begin
               offset_in = hw_next;
            end
            if (eff_pos == bmpd_pkg::POS_WIDTH) begin
               width_in = hw_next[DW-1:0];
            end
            if (eff_pos == bmpd_pkg::POS_HEIGHT) begin
               height_in   = height_mag[DW-1:0];
               top_down_in = hw_next[31];
            end
            if (eff_pos == bmpd_pkg::POS_COMPRESSION) begin
               phase_in = bmpd_pkg::PH_HEIGHT;
            end
         end
      end else if (eff_phase == bmpd_pkg::PH_HEIGHT && empty_image) begin
         phase_in = bmpd_pkg::PH_DONE;
      end else begin
         case (data_phase)
            bmpd_pkg::PH_SKIP, bmpd_pkg::PH_PIXELS: begin
               if (!pixel_now) begin
                  phase_in = bmpd_pkg::PH_SKIP;
                  pos_in   = pos_ff + 32'd1;
               end else begin
                  phase_in = bmpd_pkg::PH_PIXELS;
                  case (bip_ff)
                     2'd0: begin
                        part_in = {6'd0, b[7:3]};
                        bip_in  = 2'd1;
                     end
                     2'd1: begin
                        part_in = {b[7:2], part_ff[4:0]};
                        bip_in  = 2'd2;
                     end
                     default: begin
                        bip_in = 2'd0;
                        if (col_inc >= width_ff) begin
                           col_in  = '0;
                           frow_in = frow_inc;
                           if (frow_inc >= height_ff) begin
                              phase_in = bmpd_pkg::PH_DONE;
                           end else begin
                              pad_in = width_ff[1:0];
                              if (width_ff[1:0] != 2'd0) begin
                                 phase_in = bmpd_pkg::PH_PAD;
                              end
                           end
                        end else begin
                           col_in = col_inc;
                        end
                     end
                  endcase
               end
            end
            bmpd_pkg::PH_PAD: begin
               pad_in = pad_ff - 2'd1;
               if (pad_ff == 2'd1) begin
                  phase_in = bmpd_pkg::PH_PIXELS;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result of this item
   always_comb begin
      res_valid              = 1'b0;
      res_item.kind          = bmpd_pkg::KIND_ERROR;
      res_item.value         = '0;
      res_item.row           = '0;
      res_item.column        = '0;
      res_item.last_of_image = 1'b0;
      case (eff_phase)
         bmpd_pkg::PH_HEADER: begin
            if (hdr_fail) begin
               res_valid = 1'b1;
            end else if (eff_pos == bmpd_pkg::POS_COMPRESSION) begin
               res_valid      = 1'b1;
               res_item.kind  = bmpd_pkg::KIND_WIDTH;
               res_item.value = 16'(width_ff);
            end
         end
         bmpd_pkg::PH_HEIGHT: begin
            res_valid      = 1'b1;
            res_item.kind  = bmpd_pkg::KIND_HEIGHT;
            res_item.value = 16'(height_ff);
         end
         bmpd_pkg::PH_SKIP, bmpd_pkg::PH_PIXELS: begin
            if (pixel_now && bip_ff == 2'd2) begin
               res_valid              = 1'b1;
               res_item.kind          = bmpd_pkg::KIND_PIXEL;
               res_item.value         = pix_word;
               res_item.row           = drow_wide[10:0];
               res_item.column        = col_wide[10:0];
               res_item.last_of_image = last_pix;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= bmpd_pkg::PH_HEADER;
         pos_ff      <= '0;
         hw_ff       <= '0;
         offset_ff   <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         top_down_ff <= 1'b0;
         part_ff     <= '0;
         bip_ff      <= '0;
         col_ff      <= '0;
         frow_ff     <= '0;
         pad_ff      <= '0;
      end else if (consume) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         hw_ff       <= hw_in;
         offset_ff   <= offset_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         top_down_ff <= top_down_in;
         part_ff     <= part_in;
         bip_ff      <= bip_in;
         col_ff      <= col_in;
         frow_ff     <= frow_in;
         pad_ff      <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= consume && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_item_ff <= res_item;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.item  = out_item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bmp24_to_rgb565_stream_decoder_unit.sv =====
// Two register stages: the input register, with its skid entry, and the
// result register, which holds each result until it is taken.
// Throughput: one byte per cycle; the parser takes one item per cycle from
// its input register whenever the result register is free or being taken.
// Reset (synchronous, active high) empties both registers and puts the
// parser at header byte 0; start_of_file resets the parser for its own byte.
`default_nettype none

module bmp24_to_rgb565_stream_decoder_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   bmpd_req_if.sink   req_bus,
   bmpd_rsp_if.source rsp_bus
);

   bmpd_pkg::stage_type stage;
   logic                consume;

   bmpd_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .stage   (stage),
      .consume (consume)
   );

   bmpd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .consume (consume),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire
